FILE: hdl/irf_pkg.sv
// shared types, codes and constants of the ir channel filter and normalizer
// no dependencies; imported by every module of the block
package irf_pkg;

  localparam int CHANNELS          = 6;
  localparam int CALIB_MAX_SAMPLES = 64;
  localparam int ADC_BITS          = 12;

  localparam int SAMPLE_W = ADC_BITS;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W    = $clog2(CALIB_MAX_SAMPLES + 1);
  localparam int SUM_W    = 18;
  localparam int FILT_W   = 20;
  localparam int SCALE_W  = 16;
  localparam int ALPHA_W  = 16;
  localparam int REF_W    = 12;
  localparam int DIV_N_W  = 24;
  localparam int DIV_D_W  = 12;
  localparam int PROD_W   = 38;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // item kinds
  localparam logic [1:0] KIND_MEASURE = 2'd0;
  localparam logic [1:0] KIND_CALIB   = 2'd1;
  localparam logic [1:0] KIND_FINISH  = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BAD_CH = 2'd1;
  localparam logic [1:0] STATUS_FAILED = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_FRONT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SIDE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_DIAG  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MASK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_REF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET      = 3'd5;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 16'd16384;
  localparam logic [REF_W-1:0]   NOMINAL_RESET = 12'd2048;
  localparam logic [SCALE_W-1:0] SCALE_ONE     = 16'd4096;

  // factory reference levels and their q4.12 scales for a nominal of 2048
  localparam logic [REF_W-1:0] FACTORY_REF [CHANNELS] =
    '{12'd2790, 12'd2410, 12'd2430, 12'd2700, 12'd2900, 12'd2780};
  localparam logic [SCALE_W-1:0] FACTORY_SCALE [CHANNELS] =
    '{16'd3007, 16'd3481, 16'd3452, 16'd3107, 16'd2893, 16'd3017};

  typedef struct packed {
    logic [1:0]          kind;
    logic [2:0]          channel;
    logic [SAMPLE_W-1:0] sample;
    logic                sample_ok;
  } irf_in_t;

  typedef struct packed {
    logic [2:0]          channel_out;
    logic [SAMPLE_W-1:0] raw_value;
    logic [FILT_W-1:0]   filtered_value;
    logic [SCALE_W-1:0]  scaled_value;
    logic                value_valid;
    logic [REF_W-1:0]    reference_out;
    logic [1:0]          status;
  } irf_out_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_start;
    logic div_sel_scale;
    logic ref_write;
    logic scale_unit;
    logic scale_write;
    logic mul_go;
    logic mul_sel_ema;
    logic filt_write;
    logic out_load;
  } irf_cmd_t;

  typedef struct packed {
    logic bad;
    logic need_ema;
    logic need_div;
    logic div_done;
    logic ref_small;
  } irf_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMA_MUL,
    ST_EMA_WR,
    ST_DIV_REF,
    ST_REF_CHK,
    ST_DIV_SCALE,
    ST_SCALE_MUL,
    ST_DONE
  } irf_state_e;

endpackage

FILE: hdl/irf_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on irf_pkg for operand widths
module irf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [irf_pkg::DIV_N_W-1:0] dividend_i,
  input  logic [irf_pkg::DIV_D_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [irf_pkg::DIV_N_W-1:0] quotient_o
);
  import irf_pkg::*;

  localparam int CNT_DW = $clog2(DIV_N_W);
  localparam logic [CNT_DW-1:0] LAST = CNT_DW'(DIV_N_W - 1);

  logic                busy_q, done_q;
  logic [CNT_DW-1:0]   cnt_q;
  logic [DIV_D_W-1:0]  rem_q, dvs_q;
  logic [DIV_N_W-1:0]  quo_q;
  logic [DIV_D_W:0]    shifted;
  logic                fits;

  assign shifted = {rem_q, quo_q[DIV_N_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= DIV_D_W'(shifted - {1'b0, dvs_q});
      end else begin
        rem_q <= shifted[DIV_D_W-1:0];
      end
      quo_q <= {quo_q[DIV_N_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still iterating");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= LAST)
    else $error("divider step count past the last quotient bit");

endmodule

FILE: hdl/irf_datapath.sv
// channel state, configuration registers, shared multiplier and result register
// depends on irf_pkg and instantiates irf_div
module irf_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  irf_pkg::irf_in_t               in_data_i,
  input  logic                           cfg_we_i,
  input  logic [irf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [irf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  irf_pkg::irf_cmd_t              cmd_i,
  output irf_pkg::irf_stat_t             stat_o,
  output irf_pkg::irf_out_t              out_data_o
);
  import irf_pkg::*;

  // configuration
  logic [ALPHA_W-1:0]  alpha_front_q, alpha_side_q, alpha_diag_q;
  logic [CHANNELS-1:0] mask_q;
  logic [REF_W-1:0]    nominal_q;
  logic [SAMPLE_W-1:0] offset_q;

  // per channel state
  logic [FILT_W-1:0]  filt_q  [CHANNELS];
  logic               vld_q   [CHANNELS];
  logic [REF_W-1:0]   ref_q   [CHANNELS];
  logic [SCALE_W-1:0] scale_q [CHANNELS];
  logic [SUM_W-1:0]   csum_q  [CHANNELS];
  logic [CNT_W-1:0]   ccnt_q  [CHANNELS];

  irf_in_t                   item_q;
  logic [SAMPLE_W-1:0]       raw_q;
  logic [1:0]                status_q;
  logic signed [PROD_W-1:0]  prod_q;
  irf_out_t                  out_q;

  logic                      bad, meas_ok, calib_ok, fin;
  logic [CH_IDX_W-1:0]       ch;
  logic [SAMPLE_W-1:0]       raw_calc;
  logic [ALPHA_W-1:0]        alpha;
  logic signed [FILT_W:0]    mul_a;
  logic signed [ALPHA_W:0]   mul_b;
  logic signed [PROD_W-1:0]  ema_sum, ema_step;
  logic [PROD_W-1:0]         scl_sum;
  logic [SCALE_W-1:0]        scaled_sat;
  logic [DIV_N_W-1:0]        div_dividend, div_quo;
  logic [DIV_D_W-1:0]        div_divisor;
  logic                      div_done;

  assign bad      = 32'(item_q.channel) >= CHANNELS;
  assign ch       = bad ? '0 : item_q.channel[CH_IDX_W-1:0];
  assign raw_calc = (item_q.sample > offset_q) ? item_q.sample - offset_q : '0;
  assign meas_ok  = !bad && item_q.sample_ok && (item_q.kind == KIND_MEASURE);
  assign calib_ok = !bad && item_q.sample_ok && (item_q.kind == KIND_CALIB);
  assign fin      = !bad && (item_q.kind == KIND_FINISH);

  always_comb begin
    if (32'(ch) <= 1) begin
      alpha = alpha_front_q;
    end else if (32'(ch) == 2 || 32'(ch) == 5) begin
      alpha = alpha_side_q;
    end else begin
      alpha = alpha_diag_q;
    end
  end

  assign stat_o.bad       = bad;
  assign stat_o.need_ema  = meas_ok && vld_q[ch] && mask_q[ch];
  assign stat_o.need_div  = fin && (ccnt_q[ch] != '0);
  assign stat_o.div_done  = div_done;
  assign stat_o.ref_small = ref_q[ch] <= REF_W'(1);

  // blend as f + (r - f) * alpha, which equals the weighted sum exactly
  assign mul_a = cmd_i.mul_sel_ema
               ? $signed({1'b0, raw_q, 8'b0}) - $signed({1'b0, filt_q[ch]})
               : $signed({1'b0, filt_q[ch]});
  assign mul_b = cmd_i.mul_sel_ema ? $signed({1'b0, alpha}) : $signed({1'b0, scale_q[ch]});

  assign ema_sum  = prod_q + PROD_W'(32768);
  assign ema_step = ema_sum >>> 16;
  assign scl_sum  = prod_q + PROD_W'(32768);
  assign scaled_sat = (|scl_sum[PROD_W-1:32]) ? '1 : scl_sum[31:16];

  assign div_dividend = cmd_i.div_sel_scale
                      ? {nominal_q, 12'b0} + DIV_N_W'(ref_q[ch] >> 1)
                      : DIV_N_W'(csum_q[ch]) + DIV_N_W'(ccnt_q[ch] >> 1);
  assign div_divisor  = cmd_i.div_sel_scale ? ref_q[ch] : DIV_D_W'(ccnt_q[ch]);

  irf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_front_q <= ALPHA_RESET;
      alpha_side_q  <= ALPHA_RESET;
      alpha_diag_q  <= ALPHA_RESET;
      mask_q        <= '0;
      nominal_q     <= NOMINAL_RESET;
      offset_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ALPHA_FRONT: alpha_front_q <= cfg_data_i[ALPHA_W-1:0];
        CFG_ALPHA_SIDE:  alpha_side_q  <= cfg_data_i[ALPHA_W-1:0];
        CFG_ALPHA_DIAG:  alpha_diag_q  <= cfg_data_i[ALPHA_W-1:0];
        CFG_FILTER_MASK: mask_q        <= cfg_data_i[CHANNELS-1:0];
        CFG_NOMINAL_REF: nominal_q     <= cfg_data_i[REF_W-1:0];
        CFG_OFFSET:      offset_q      <= cfg_data_i[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        filt_q[c]  <= '0;
        vld_q[c]   <= 1'b0;
        ref_q[c]   <= FACTORY_REF[c];
        scale_q[c] <= FACTORY_SCALE[c];
        csum_q[c]  <= '0;
        ccnt_q[c]  <= '0;
      end
    end else begin
      if (cmd_i.eval) begin
        if (meas_ok && !(vld_q[ch] && mask_q[ch])) begin
          filt_q[ch] <= {raw_calc, 8'b0};
          vld_q[ch]  <= 1'b1;
        end
        if (calib_ok && 32'(ccnt_q[ch]) < CALIB_MAX_SAMPLES) begin
          csum_q[ch] <= csum_q[ch] + SUM_W'(raw_calc);
          ccnt_q[ch] <= ccnt_q[ch] + 1'b1;
        end
        if (fin) begin
          csum_q[ch] <= '0;
          ccnt_q[ch] <= '0;
          if (ccnt_q[ch] == '0) begin
            ref_q[ch]   <= '0;
            scale_q[ch] <= SCALE_ONE;
          end
        end
      end
      if (cmd_i.filt_write) begin
        filt_q[ch] <= filt_q[ch] + ema_step[FILT_W-1:0];
      end
      if (cmd_i.ref_write) begin
        ref_q[ch] <= div_quo[REF_W-1:0];
      end
      if (cmd_i.scale_unit) begin
        scale_q[ch] <= SCALE_ONE;
      end
      if (cmd_i.scale_write) begin
        scale_q[ch] <= (|div_quo[DIV_N_W-1:SCALE_W]) ? '1 : div_quo[SCALE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.eval) begin
      raw_q <= (meas_ok || calib_ok) ? raw_calc : '0;
      if (bad) begin
        status_q <= STATUS_BAD_CH;
      end else if (!item_q.sample_ok &&
                   (item_q.kind == KIND_MEASURE || item_q.kind == KIND_CALIB)) begin
        status_q <= STATUS_FAILED;
      end else begin
        status_q <= STATUS_OK;
      end
    end
    if (cmd_i.mul_go) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd_i.out_load) begin
      out_q.channel_out    <= item_q.channel;
      out_q.raw_value      <= raw_q;
      out_q.filtered_value <= bad ? '0 : filt_q[ch];
      out_q.scaled_value   <= (bad || !vld_q[ch]) ? '0 : scaled_sat;
      out_q.value_valid    <= !bad && vld_q[ch];
      out_q.reference_out  <= bad ? '0 : ref_q[ch];
      out_q.status         <= status_q;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: hdl/irf_ctrl.sv
// sequencing state machine and output beat handshake
// depends on irf_pkg for the state, command and status types
module irf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  irf_pkg::irf_stat_t stat_i,
  output irf_pkg::irf_cmd_t  cmd_o
);
  import irf_pkg::*;

  irf_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat_i.bad) begin
          state_d = ST_DONE;
        end else if (stat_i.need_ema) begin
          state_d = ST_EMA_MUL;
        end else if (stat_i.need_div) begin
          state_d = ST_DIV_REF;
        end else begin
          state_d = ST_SCALE_MUL;
        end
      end
      ST_EMA_MUL:   state_d = ST_EMA_WR;
      ST_EMA_WR:    state_d = ST_SCALE_MUL;
      ST_DIV_REF: begin
        if (stat_i.div_done) state_d = ST_REF_CHK;
      end
      ST_REF_CHK: begin
        state_d = stat_i.ref_small ? ST_SCALE_MUL : ST_DIV_SCALE;
      end
      ST_DIV_SCALE: begin
        if (stat_i.div_done) state_d = ST_SCALE_MUL;
      end
      ST_SCALE_MUL: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EVAL: begin
        cmd_o.eval      = 1'b1;
        cmd_o.div_start = !stat_i.bad && !stat_i.need_ema && stat_i.need_div;
      end
      ST_EMA_MUL: begin
        cmd_o.mul_go      = 1'b1;
        cmd_o.mul_sel_ema = 1'b1;
      end
      ST_EMA_WR: begin
        cmd_o.mul_sel_ema = 1'b1;
        cmd_o.filt_write  = 1'b1;
      end
      ST_DIV_REF: begin
        cmd_o.ref_write = stat_i.div_done;
      end
      ST_REF_CHK: begin
        cmd_o.div_sel_scale = 1'b1;
        cmd_o.scale_unit    = stat_i.ref_small;
        cmd_o.div_start     = !stat_i.ref_small;
      end
      ST_DIV_SCALE: begin
        cmd_o.div_sel_scale = 1'b1;
        cmd_o.scale_write   = stat_i.div_done;
      end
      ST_SCALE_MUL: begin
        cmd_o.mul_go = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_EVAL)
    else $error("accepted beat not evaluated next cycle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

  a_div_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !stat_i.div_done)
    else $error("stale divider done after a new start");

endmodule

FILE: hdl/ir_channel_filter_normalizer.sv
// top level of the ir channel filter and normalizer
// depends on irf_pkg; instantiates irf_ctrl and irf_datapath
//
// Six ir channels each keep a filter value (q12.8), a valid flag, a reference
// level, a q4.12 scale and a calibration sum and count. One result beat comes
// out for every input beat. A measure beat subtracts the dark offset (clamped
// at zero); the first good sample of a channel loads its filter, later ones
// replace it or blend in by an ema when the channel's mask bit is set. The
// scaled value is filter * scale, rounded to q12.4 and saturated. Calibration
// beats accumulate up to 64 good samples; a finish beat sets the reference to
// the rounded average and the scale to nominal / reference, unity for 0 or 1.
// Sequencing: the block works on one beat at a time. After the accept, a
// measure without blending, a failed read, a calibration sample, an unused
// kind or a finish with no samples passes the eval and scale multiply steps
// before the result register is loaded; a bad channel goes from eval straight
// to the result. A blended measure first takes the blend multiply and filter
// write on the registered multiplier that serves the blend and then the
// scaling. A finish beat with samples runs the serial divider (24 quotient
// bits, one per cycle) once for the average and once for the new scale; the
// second division is skipped for a new reference of 0 or 1. A new result is
// loaded only once the one before it is taken; the next beat is accepted
// while a finished result still waits in the output register. Configuration
// must be written through cfg_we_i / cfg_index_i / cfg_data_i while the block
// is idle, not enforced by it; nominal_reference takes effect on the next finish.
module ir_channel_filter_normalizer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input beats
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  irf_pkg::irf_in_t               in_data_i,
  // result beats
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output irf_pkg::irf_out_t              out_data_o,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [irf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [irf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import irf_pkg::*;

  irf_cmd_t  cmd;
  irf_stat_t stat;

  // sequencer: walks each beat through eval, multiply and divide steps
  irf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // channel state, config, shared multiplier, divider and result register
  irf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/sv/tb_ir_channel_filter_normalizer.sv
`timescale 1ns / 100ps
// self-checking testbench of ir_channel_filter_normalizer: directed and random beats
// checked field by field against an in-bench channel model; depends on irf_pkg and the rtl
module tb_ir_channel_filter_normalizer;
  import irf_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT  = 800000;
  localparam int PHASES       = 9;
  localparam int PHASE_BEATS  = 200;
  localparam int HOLD_AT_BEAT = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 80;
  localparam int PRINT_CAP    = 40;

  // dut connections, all inputs known from time zero
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  irf_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  irf_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // channel model: configuration copy and per-channel state
  logic [ALPHA_W-1:0]  alpha_front_q, alpha_side_q, alpha_diag_q;
  logic [CHANNELS-1:0] blend_mask_q;
  logic [REF_W-1:0]    nominal_q;
  logic [SAMPLE_W-1:0] offset_q;
  logic [FILT_W-1:0]   filt_q       [CHANNELS];
  logic                chan_valid_q [CHANNELS];
  logic [REF_W-1:0]    ref_q        [CHANNELS];
  logic [SCALE_W-1:0]  scale_q      [CHANNELS];
  logic [SUM_W-1:0]    cal_sum_q    [CHANNELS];
  logic [CNT_W-1:0]    cal_cnt_q    [CHANNELS];

  // beats waiting for the driver and results waiting for the monitor
  irf_in_t  pending_beats[$];
  irf_out_t predicted_results[$];

  int send_idle_pct = 37;
  int recv_idle_pct = 63;
  int beats_in      = 0;
  int results_seen  = 0;
  int err_count     = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int unsigned cycle_count = 0;

  // coverage tallies kept by the model
  int blend_count    = 0;
  int finish_count   = 0;
  int failed_count   = 0;
  int bad_ch_count   = 0;
  int overflow_count = 0;

  ir_channel_filter_normalizer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // nominal * 4096 / reference, rounded; tiny references fall back to unity
  function automatic logic [SCALE_W-1:0] scale_for(logic [REF_W-1:0] lvl);
    logic [63:0] q;
    if (lvl <= 1) return SCALE_ONE;
    q = (64'(nominal_q) * 64'd4096 + 64'(lvl >> 1)) / 64'(lvl);
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic [SCALE_W-1:0] scaled_of(int ch);
    logic [63:0] p;
    if (!chan_valid_q[ch]) return '0;
    p = (64'(filt_q[ch]) * 64'(scale_q[ch]) + 64'd32768) >> 16;
    return (p > 64'd65535) ? 16'hFFFF : p[15:0];
  endfunction

  // front pair, side pair, everything else diagonal
  function automatic logic [ALPHA_W-1:0] alpha_for(int ch);
    if (ch <= 1) return alpha_front_q;
    if (ch == 2 || ch == 5) return alpha_side_q;
    return alpha_diag_q;
  endfunction

  task automatic reset_model();
    alpha_front_q = ALPHA_RESET;
    alpha_side_q  = ALPHA_RESET;
    alpha_diag_q  = ALPHA_RESET;
    blend_mask_q  = '0;
    nominal_q     = NOMINAL_RESET;
    offset_q      = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      filt_q[c]       = '0;
      chan_valid_q[c] = 1'b0;
      ref_q[c]        = FACTORY_REF[c];
      scale_q[c]      = scale_for(FACTORY_REF[c]);
      cal_sum_q[c]    = '0;
      cal_cnt_q[c]    = '0;
    end
  endtask

  // advances the channel model by one accepted beat and returns its result
  function automatic irf_out_t compute_channel_result(irf_in_t b);
    irf_out_t            r;
    int                  ch;
    logic [SAMPLE_W-1:0] raw;
    logic [FILT_W-1:0]   raw_q8;
    logic [ALPHA_W-1:0]  a;
    logic [63:0]         acc;
    logic [31:0]         n;
    logic [31:0]         avg;
    r = '0;
    r.channel_out = b.channel;
    ch = 32'(b.channel);
    // bad channel: nothing but the channel and the status
    if (ch >= CHANNELS) begin
      bad_ch_count++;
      r.status = STATUS_BAD_CH;
      return r;
    end
    raw = '0;
    if (b.kind == KIND_MEASURE || b.kind == KIND_CALIB) begin
      if (!b.sample_ok) begin
        // failed read leaves filter and calibration alone
        failed_count++;
        r.status = STATUS_FAILED;
      end else begin
        raw = (b.sample > offset_q) ? b.sample - offset_q : '0;
        if (b.kind == KIND_MEASURE) begin
          raw_q8 = {raw, 8'h00};
          if (!chan_valid_q[ch] || !blend_mask_q[ch]) begin
            filt_q[ch]       = raw_q8;
            chan_valid_q[ch] = 1'b1;
          end else begin
            a   = alpha_for(ch);
            acc = 64'(filt_q[ch]) * (64'd65536 - 64'(a)) + 64'(raw_q8) * 64'(a) + 64'd32768;
            filt_q[ch] = acc[35:16];
            blend_count++;
          end
        end else if (cal_cnt_q[ch] < CALIB_MAX_SAMPLES) begin
          cal_sum_q[ch] = cal_sum_q[ch] + SUM_W'(raw);
          cal_cnt_q[ch] = cal_cnt_q[ch] + 1'b1;
        end else begin
          overflow_count++;
        end
      end
    end else if (b.kind == KIND_FINISH) begin
      // rounded average, zero when no good sample came in
      n   = 32'(cal_cnt_q[ch]);
      avg = (n != 0) ? (32'(cal_sum_q[ch]) + n / 2) / n : 32'd0;
      ref_q[ch]     = avg[REF_W-1:0];
      scale_q[ch]   = scale_for(ref_q[ch]);
      cal_sum_q[ch] = '0;
      cal_cnt_q[ch] = '0;
      finish_count++;
    end
    r.raw_value      = raw;
    r.filtered_value = filt_q[ch];
    r.scaled_value   = scaled_of(ch);
    r.value_valid    = chan_valid_q[ch];
    r.reference_out  = ref_q[ch];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  task automatic check_result(irf_out_t got);
    irf_out_t want;
    if (predicted_results.size() == 0) begin
      report_mismatch("result beat with nothing pending, channel", 32'(got.channel_out), 0);
      return;
    end
    want = predicted_results.pop_front();
    results_seen++;
    compare_field("channel_out", 32'(got.channel_out), 32'(want.channel_out));
    compare_field("raw_value", 32'(got.raw_value), 32'(want.raw_value));
    compare_field("filtered_value", 32'(got.filtered_value), 32'(want.filtered_value));
    compare_field("scaled_value", 32'(got.scaled_value), 32'(want.scaled_value));
    compare_field("value_valid", 32'(got.value_valid), 32'(want.value_valid));
    compare_field("reference_out", 32'(got.reference_out), 32'(want.reference_out));
    compare_field("status", 32'(got.status), 32'(want.status));
  endtask

  // driver: predicts on every accepted beat, then offers the next one
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_results.push_back(compute_channel_result(in_data));
        beats_in++;
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off so the block backs up onto its input
  always @(posedge clk) begin
    if (hold_left != 0)
      hold_left <= hold_left - 1;
    else if (!hold_done && beats_in >= HOLD_AT_BEAT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // monitor: checks every accepted result beat, stalls at random
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               predicted_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_beat(input logic [1:0] kind, input int ch, input int smp, input bit ok);
    irf_in_t b;
    b.kind      = kind;
    b.channel   = ch[2:0];
    b.sample    = smp[SAMPLE_W-1:0];
    b.sample_ok = ok;
    pending_beats.push_back(b);
  endtask

  // sender quiet and every result back; checked on the falling edge where all is settled
  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || predicted_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_ALPHA_FRONT: alpha_front_q = val;
      CFG_ALPHA_SIDE:  alpha_side_q  = val;
      CFG_ALPHA_DIAG:  alpha_diag_q  = val;
      CFG_FILTER_MASK: blend_mask_q  = val[CHANNELS-1:0];
      CFG_NOMINAL_REF: nominal_q     = val[REF_W-1:0];
      CFG_OFFSET:      offset_q      = val[SAMPLE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int af, input int as, input int ad, input int mask,
                            input int nom, input int off);
    write_reg(CFG_ALPHA_FRONT, af[15:0]);
    write_reg(CFG_ALPHA_SIDE, as[15:0]);
    write_reg(CFG_ALPHA_DIAG, ad[15:0]);
    write_reg(CFG_FILTER_MASK, mask[15:0]);
    write_reg(CFG_NOMINAL_REF, nom[15:0]);
    write_reg(CFG_OFFSET, off[15:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // mostly calibration runs ending in a finish and measure bursts, some raw noise
  task automatic queue_random_beats(int count);
    int pushed, ch, len, level, s, sel;
    pushed = 0;
    while (pushed < count) begin
      sel = $urandom_range(99);
      if (sel < 14) begin
        ch    = $urandom_range(CHANNELS - 1);
        len   = ($urandom_range(9) == 0) ? $urandom_range(70, 60) : $urandom_range(8);
        level = $urandom_range(4095);
        for (int i = 0; i < len; i++) begin
          s = $urandom_range(64);
          s = level + s - 32;
          if (s < 0) s = 0;
          if (s > 4095) s = 4095;
          push_beat(KIND_CALIB, ch, s, $urandom_range(11) != 0);
          pushed++;
          if ($urandom_range(15) == 0) begin
            push_beat(KIND_MEASURE, $urandom_range(CHANNELS - 1), $urandom_range(4095), 1'b1);
            pushed++;
          end
        end
        push_beat(KIND_FINISH, ch, $urandom_range(4095), 1'($urandom_range(1)));
        pushed++;
      end else if (sel < 20) begin
        push_beat(2'($urandom_range(3)), $urandom_range(7), $urandom_range(4095),
                  1'($urandom_range(1)));
        pushed++;
      end else begin
        ch    = ($urandom_range(15) == 0) ? $urandom_range(7, CHANNELS)
                                          : $urandom_range(CHANNELS - 1);
        len   = $urandom_range(6, 1);
        level = $urandom_range(4095);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(3) == 0) begin
            s = $urandom_range(4095);
          end else begin
            s = $urandom_range(256);
            s = level + s - 128;
            if (s < 0) s = 0;
            if (s > 4095) s = 4095;
          end
          push_beat(KIND_MEASURE, ch, s, $urandom_range(19) != 0);
          pushed++;
        end
      end
    end
  endtask

  initial begin
    reset_model();
    wait (rst_n === 1'b1);
    @(negedge clk);

    // directed, reset configuration
    push_beat(KIND_MEASURE, 0, 0, 1'b1);        // first good sample loads the filter
    push_beat(KIND_MEASURE, 0, 4095, 1'b1);     // mask clear: plain replace
    push_beat(KIND_MEASURE, 1, 4095, 1'b0);     // failed read on a channel not yet valid
    push_beat(KIND_MEASURE, 6, 4095, 1'b1);     // bad channel
    push_beat(KIND_UNUSED, 7, 0, 1'b0);         // bad channel, unused kind
    push_beat(KIND_UNUSED, 2, 1234, 1'b1);      // unused kind reports state only
    push_beat(KIND_CALIB, 3, 100, 1'b1);
    push_beat(KIND_CALIB, 3, 103, 1'b1);
    push_beat(KIND_CALIB, 3, 4095, 1'b0);       // failed calibration read is dropped
    push_beat(KIND_FINISH, 3, 0, 1'b0);         // average rounds half up
    push_beat(KIND_FINISH, 4, 4095, 1'b1);      // finish with no samples gives reference zero
    push_beat(KIND_CALIB, 5, 1, 1'b1);
    push_beat(KIND_FINISH, 5, 0, 1'b1);         // reference one keeps unity scale
    push_beat(KIND_FINISH, 7, 0, 1'b1);
    push_beat(KIND_CALIB, 6, 2000, 1'b1);
    for (int c = 0; c < CHANNELS; c++) push_beat(KIND_MEASURE, c, c * 700 + 5, 1'b1);
    wait_idle();

    // directed, blending on, extreme weights, high nominal, nonzero offset
    set_config(65535, 0, 32'(ALPHA_RESET), 63, 4095, 100);
    push_beat(KIND_MEASURE, 0, 4095, 1'b1);     // near full weight on the new sample
    push_beat(KIND_MEASURE, 2, 50, 1'b1);       // below offset clamps, zero weight holds filter
    push_beat(KIND_CALIB, 1, 102, 1'b1);
    push_beat(KIND_FINISH, 1, 0, 1'b1);         // tiny reference saturates the scale
    push_beat(KIND_MEASURE, 1, 4095, 1'b1);     // scaled value saturates
    push_beat(KIND_MEASURE, 3, 4095, 1'b1);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 63;
      end else if (p < 6) begin
        send_idle_pct = 63;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: set_config(32'(ALPHA_RESET), 32'(ALPHA_RESET), 32'(ALPHA_RESET), 0,
                      32'(NOMINAL_RESET), 0);
        1: set_config(0, 65535, $urandom_range(65535), 63, 4095, 0);
        2: set_config($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                      $urandom_range(63), 1, 4095);
        3: set_config(65535, 65535, 65535, 63, $urandom_range(4095, 1), $urandom_range(200));
        4: set_config(0, 0, 0, $urandom_range(63), $urandom_range(4095, 1), 0);
        5: set_config($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                      $urandom_range(63), $urandom_range(4095, 1), $urandom_range(4095));
        6: set_config($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                      63, $urandom_range(4095, 1), $urandom_range(300));
        7: set_config(65535, 0, 0, $urandom_range(63), 4095, 0);
        default: set_config($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                            $urandom_range(63), $urandom_range(4095, 1), $urandom_range(400));
      endcase
      queue_random_beats(PHASE_BEATS);
      // sender holds back here until every result of the phase is in
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (predicted_results.size() != 0)
      report_mismatch("results never delivered", predicted_results.size(), 0);

    $display("covered %0d beats over %0d settings: %0d ema blends, %0d finishes, %0d failed reads",
             beats_in, PHASES + 2, blend_count, finish_count, failed_count);
    $display("  %0d bad-channel beats, %0d calibration samples past the limit, %0d results checked",
             bad_ch_count, overflow_count, results_seen);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/irf_pkg.sv
hdl/irf_div.sv
hdl/irf_datapath.sv
hdl/irf_ctrl.sv
hdl/ir_channel_filter_normalizer.sv
tb/sv/tb_ir_channel_filter_normalizer.sv
